FILE: rtl/core/kpi_pkg.sv
// Shared types and default sizes for the keyframe pose interpolator.
package kpi_pkg;

  localparam int MOTIONS_DEF    = 8;
  localparam int KEYS_DEF       = 16;
  localparam int PARTS_DEF      = 16;
  localparam int VALUE_BITS_DEF = 16;
  localparam int CHANNELS       = 6;

  typedef enum logic [2:0] {
    REQ_KEY_VALUE  = 3'd0,
    REQ_KEY_FRAMES = 3'd1,
    REQ_HEADER     = 3'd2,
    REQ_ORIGIN     = 3'd3,
    REQ_SELECT     = 3'd4,
    REQ_TICK       = 3'd5
  } kpi_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR,
    ST_FR,
    ST_RD_A,
    ST_RD_B,
    ST_MUL,
    ST_DIVS,
    ST_DIVW,
    ST_OUT
  } kpi_state_t;

endpackage

FILE: rtl/core/kpi_if.sv
// Request and pose result channel interfaces.
interface kpi_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [2:0]         motion_index;
  logic [3:0]         key_index;
  logic [3:0]         part_index;
  logic [2:0]         channel;
  logic signed [15:0] value;
  logic [7:0]         frames;
  logic [4:0]         key_count;
  logic               loop_enable;

  modport source(output valid, req_type, motion_index, key_index, part_index, channel,
                 value, frames, key_count, loop_enable, input ready);
  modport sink(input valid, req_type, motion_index, key_index, part_index, channel,
               value, frames, key_count, loop_enable, output ready);
endinterface

interface kpi_rsp_if #(
  parameter int VALUE_BITS = kpi_pkg::VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [3:0]                   part_id;
  logic signed [VALUE_BITS-1:0] pos_x;
  logic signed [VALUE_BITS-1:0] pos_y;
  logic signed [VALUE_BITS-1:0] pos_z;
  logic signed [VALUE_BITS-1:0] rot_x;
  logic signed [VALUE_BITS-1:0] rot_y;
  logic signed [VALUE_BITS-1:0] rot_z;
  logic                         last;
  logic                         finished;

  modport source(output valid, part_id, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z, last,
                 finished, input ready);
  modport sink(input valid, part_id, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z, last,
               finished, output ready);
endinterface

FILE: rtl/core/keyframe_pose_interpolator.sv
// Top level: request decode, key tables and the tick sequencer around a shared divider.
// Loads and selects are taken in the idle state; a tick that does not animate only visits
// the header state. An animating tick runs the bit-serial divider once per channel of
// each part, and a stalled result holds.
// Synchronous reset clears the active motion, key, frame counter, finished flag and
// part count (to one); the key tables are undefined until loaded.
module keyframe_pose_interpolator #(
  parameter int MOTIONS    = kpi_pkg::MOTIONS_DEF,
  parameter int KEYS       = kpi_pkg::KEYS_DEF,
  parameter int PARTS      = kpi_pkg::PARTS_DEF,
  parameter int VALUE_BITS = kpi_pkg::VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_data,
  kpi_req_if.sink    req,
  kpi_rsp_if.source  rsp
);
  import kpi_pkg::*;

  localparam int MW     = (MOTIONS > 1) ? $clog2(MOTIONS) : 1;
  localparam int KW     = $clog2(KEYS);
  localparam int PW     = (PARTS > 1) ? $clog2(PARTS) : 1;
  localparam int CNTW   = $clog2(KEYS + 1);
  localparam int NW     = $clog2(PARTS + 1);
  localparam int KV_AW  = MW + KW + PW + 3;
  localparam int KF_AW  = MW + KW;
  localparam int OR_AW  = PW + 2;
  localparam int DIFFW  = VALUE_BITS + 1;
  localparam int PRODW  = VALUE_BITS + 10;
  localparam int SUMW   = VALUE_BITS + 12;
  localparam logic signed [SUMW-1:0] SAT_HI = SUMW'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
  localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

  kpi_state_t state, state_next;

  logic [4:0]            part_count;
  logic [MW-1:0]         active_motion;
  logic [CNTW-1:0]       cur_key;
  logic [7:0]            frame_cnt;
  logic                  fin;
  logic [CNTW-1:0]       mot_cnt  [MOTIONS];
  logic                  mot_loop [MOTIONS];

  // Per-tick working registers.
  logic [CNTW-1:0]       key_cur;
  logic [KW-1:0]         nk_key;
  logic [CNTW-1:0]       cnt_l;
  logic                  loop_l;
  logic [NW-1:0]         n_parts;
  logic [7:0]            fcur;
  logic [CNTW-1:0]       upd_key;
  logic [7:0]            upd_cnt;
  logic                  upd_fin;
  logic [PW-1:0]         part_i;
  logic [2:0]            ch_i;
  logic signed [VALUE_BITS-1:0] a_val;
  logic signed [VALUE_BITS-1:0] org;
  logic signed [PRODW-1:0]      prod;
  logic signed [VALUE_BITS-1:0] res [CHANNELS];

  // Request decode.
  logic                  req_fire;
  logic [31:0]           m32, k32, p32, kc32, kcc32, pc32, npc32;
  logic                  m_ok, k_ok, p_ok, ch_ok;
  int                    v32, vsat;
  logic [VALUE_BITS-1:0] val_sat;

  // RAM ports.
  logic                  kv_we, kf_we, or_we;
  logic [KV_AW-1:0]      kv_waddr, kv_raddr;
  logic [KF_AW-1:0]      kf_waddr, kf_raddr;
  logic [OR_AW-1:0]      or_waddr, or_raddr;
  logic [VALUE_BITS-1:0] kv_rdata, or_rdata;
  logic [7:0]            kf_wdata, kf_rdata;

  // Tick arithmetic.
  logic [CNTW-1:0]       cnt_a, key_fix, key_inc, nk_full, key2;
  logic                  loop_a, animate;
  logic [7:0]            fcur_c;
  logic [8:0]            nc;
  logic                  step, wrap;
  logic signed [VALUE_BITS:0]   diff;
  logic signed [PRODW-1:0]      prod_c;
  logic [PRODW-1:0]      mag;
  logic                  div_start, div_busy, div_done;
  logic [PRODW-1:0]      div_q;
  logic signed [SUMW-1:0]       q_s, sum;
  logic signed [VALUE_BITS-1:0] sum_sat;
  logic                  last_part;

  assign req_fire = req.valid && req.ready;
  assign m32  = 32'(req.motion_index);
  assign k32  = 32'(req.key_index);
  assign p32  = 32'(req.part_index);
  assign kc32 = 32'(req.key_count);
  assign m_ok  = m32 < 32'(MOTIONS);
  assign k_ok  = k32 < 32'(KEYS);
  assign p_ok  = p32 < 32'(PARTS);
  assign ch_ok = req.channel < 3'(CHANNELS);
  assign kcc32 = (kc32 == 0) ? 32'd1 : ((kc32 > 32'(KEYS)) ? 32'(KEYS) : kc32);
  assign pc32  = 32'(part_count);
  assign npc32 = (pc32 == 0) ? 32'd1 : ((pc32 > 32'(PARTS)) ? 32'(PARTS) : pc32);

  always_comb begin
    v32  = int'(req.value);
    vsat = v32;
    if (64'(signed'(v32)) > 64'(SAT_HI)) begin
      vsat = int'(SAT_HI);
    end else if (64'(signed'(v32)) < 64'(SAT_LO)) begin
      vsat = int'(SAT_LO);
    end
    val_sat = VALUE_BITS'(vsat);
  end

  assign kv_we    = req_fire && req.req_type == REQ_KEY_VALUE && m_ok && k_ok && p_ok && ch_ok;
  assign kv_waddr = {m32[MW-1:0], k32[KW-1:0], p32[PW-1:0], req.channel};
  assign kf_we    = req_fire && req.req_type == REQ_KEY_FRAMES && m_ok && k_ok;
  assign kf_waddr = {m32[MW-1:0], k32[KW-1:0]};
  assign kf_wdata = (req.frames == 8'd0) ? 8'd1 : req.frames;
  assign or_we    = req_fire && req.req_type == REQ_ORIGIN && p_ok && req.channel < 3'd3;
  assign or_waddr = {p32[PW-1:0], req.channel[1:0]};

  kpi_ram #(.WIDTH(VALUE_BITS), .DEPTH(2 ** KV_AW)) u_kv_ram (
    .clk(clk), .we(kv_we), .waddr(kv_waddr), .wdata(val_sat),
    .raddr(kv_raddr), .rdata(kv_rdata)
  );

  kpi_ram #(.WIDTH(8), .DEPTH(2 ** KF_AW)) u_kf_ram (
    .clk(clk), .we(kf_we), .waddr(kf_waddr), .wdata(kf_wdata),
    .raddr(kf_raddr), .rdata(kf_rdata)
  );

  kpi_ram #(.WIDTH(VALUE_BITS), .DEPTH(2 ** OR_AW)) u_or_ram (
    .clk(clk), .we(or_we), .waddr(or_waddr), .wdata(val_sat),
    .raddr(or_raddr), .rdata(or_rdata)
  );

  // Header step: a looping motion with a stale key restarts at key zero.
  assign cnt_a   = mot_cnt[active_motion];
  assign loop_a  = mot_loop[active_motion];
  assign key_fix = (loop_a && cur_key >= cnt_a) ? '0 : cur_key;
  assign animate = loop_a || key_fix < cnt_a;
  assign key_inc = key_fix + 1'b1;
  assign nk_full = (key_inc == cnt_a) ? '0 : key_inc;

  // Frame step: the counter update is known before any pose is produced.
  assign fcur_c = (kf_rdata == 8'd0) ? 8'd1 : kf_rdata;
  assign nc     = {1'b0, frame_cnt} + 9'd1;
  assign step   = nc >= {1'b0, fcur_c};
  assign key2   = step ? key_cur + 1'b1 : key_cur;
  assign wrap   = key2 >= cnt_l;

  assign diff   = DIFFW'($signed(kv_rdata)) - DIFFW'(a_val);
  assign prod_c = PRODW'(diff) * $signed({2'b00, frame_cnt});
  assign mag    = prod[PRODW-1] ? PRODW'(-prod) : PRODW'(prod);

  kpi_div #(.MAGW(PRODW)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(mag + PRODW'(fcur >> 1)), .divisor(fcur),
    .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  always_comb begin
    q_s = SUMW'(div_q);
    if (prod[PRODW-1]) begin
      q_s = -q_s;
    end
    sum = SUMW'(a_val) + q_s + SUMW'(org);
    if (sum > SAT_HI) begin
      sum_sat = VALUE_BITS'(SAT_HI);
    end else if (sum < SAT_LO) begin
      sum_sat = VALUE_BITS'(SAT_LO);
    end else begin
      sum_sat = VALUE_BITS'(sum);
    end
  end

  assign last_part = 32'(part_i) + 32'd1 == 32'(n_parts);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire && req.req_type == REQ_TICK) begin
          state_next = ST_HDR;
        end
      end
      ST_HDR:  state_next = animate ? ST_FR : ST_IDLE;
      ST_FR:   state_next = ST_RD_A;
      ST_RD_A: state_next = ST_RD_B;
      ST_RD_B: state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIVS;
      ST_DIVS: state_next = ST_DIVW;
      ST_DIVW: begin
        if (div_done) begin
          state_next = (ch_i == 3'(CHANNELS - 1)) ? ST_OUT : ST_RD_A;
        end
      end
      ST_OUT: begin
        if (rsp.ready) begin
          state_next = last_part ? ST_IDLE : ST_RD_A;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    rsp.valid = 1'b0;
    div_start = 1'b0;
    kv_raddr  = {active_motion, key_cur[KW-1:0], part_i, ch_i};
    kf_raddr  = {active_motion, key_fix[KW-1:0]};
    or_raddr  = {part_i, ch_i[1:0]};
    case (state)
      ST_IDLE: req.ready = 1'b1;
      ST_RD_B: kv_raddr  = {active_motion, nk_key, part_i, ch_i};
      ST_DIVS: div_start = 1'b1;
      ST_OUT:  rsp.valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      part_count    <= 5'd1;
      active_motion <= '0;
      cur_key       <= '0;
      frame_cnt     <= '0;
      fin           <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        part_count <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (req_fire && req.req_type == REQ_SELECT && m_ok
              && m32[MW-1:0] != active_motion) begin
            active_motion <= m32[MW-1:0];
            cur_key       <= '0;
            frame_cnt     <= '0;
            fin           <= 1'b0;
          end
        end
        ST_HDR: cur_key <= key_fix;
        ST_OUT: begin
          if (rsp.ready && last_part) begin
            cur_key   <= upd_key;
            frame_cnt <= upd_cnt;
            fin       <= upd_fin;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire && req.req_type == REQ_HEADER && m_ok) begin
      mot_cnt[m32[MW-1:0]]  <= CNTW'(kcc32);
      mot_loop[m32[MW-1:0]] <= req.loop_enable;
    end
    case (state)
      ST_HDR: begin
        key_cur <= key_fix;
        nk_key  <= nk_full[KW-1:0];
        cnt_l   <= cnt_a;
        loop_l  <= loop_a;
        n_parts <= NW'(npc32);
      end
      ST_FR: begin
        fcur    <= fcur_c;
        upd_key <= (wrap && loop_l) ? '0 : key2;
        upd_cnt <= step ? 8'd0 : nc[7:0];
        upd_fin <= fin | (wrap & ~loop_l);
        part_i  <= '0;
        ch_i    <= '0;
      end
      ST_RD_B: a_val <= VALUE_BITS'(kv_rdata);
      ST_MUL: begin
        prod <= prod_c;
        org  <= (ch_i < 3'd3) ? VALUE_BITS'(or_rdata) : '0;
      end
      ST_DIVW: begin
        if (div_done) begin
          res[ch_i] <= sum_sat;
          ch_i      <= ch_i + 3'd1;
        end
      end
      ST_OUT: begin
        if (rsp.ready) begin
          part_i <= part_i + 1'b1;
          ch_i   <= '0;
        end
      end
      default: ;
    endcase
  end

  assign rsp.part_id  = 4'(part_i);
  assign rsp.pos_x    = res[0];
  assign rsp.pos_y    = res[1];
  assign rsp.pos_z    = res[2];
  assign rsp.rot_x    = res[3];
  assign rsp.rot_y    = res[4];
  assign rsp.rot_z    = res[5];
  assign rsp.last     = last_part;
  assign rsp.finished = upd_fin;

`ifndef SYNTHESIS
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !rsp.valid)
    else $error("request accepted while a pose is pending");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.ready && rsp.last) |=> req.ready)
    else $error("block not idle after the last pose of a tick");
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == ST_DIVW))
    else $error("divider running outside its wait state");
  a_part_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> (32'(part_i) < 32'(n_parts)))
    else $error("part index beyond the part count");
`endif
endmodule

FILE: rtl/core/kpi_ram.sv
// Generic single write port, single read port RAM with registered read.
module kpi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/kpi_div.sv
// Restoring divider, one quotient bit per cycle, for the interpolation quotient.
module kpi_div #(
  parameter int MAGW = 26
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [MAGW-1:0] dividend,
  input  logic [7:0]      divisor,
  output logic            busy,
  output logic            done,
  output logic [MAGW-1:0] quotient
);
  localparam int CNTW = $clog2(MAGW + 1);

  logic [CNTW-1:0] cnt;
  logic [MAGW-1:0] dvd;
  logic [7:0]      rem;
  logic [7:0]      dsr;
  logic [8:0]      trial;
  logic            qbit;

  assign trial    = {rem, dvd[MAGW-1]};
  assign qbit     = trial >= {1'b0, dsr};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(MAGW);
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        // The remainder stays below the divisor, so eight bits hold it.
        rem <= qbit ? 8'(trial - {1'b0, dsr}) : trial[7:0];
        dvd <= {dvd[MAGW-2:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: sim/tb_keyframe_pose_interpolator.sv
// Self-checking testbench for the keyframe pose interpolator with a built-in pose predictor.
`timescale 1ns / 1ps

module tb_keyframe_pose_interpolator;
  import kpi_pkg::*;

  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;
  localparam int IDLE_LIMIT = 4000;

  typedef struct {
    logic [2:0]         kind;
    logic [2:0]         motion;
    logic [3:0]         key;
    logic [3:0]         part;
    logic [2:0]         chan;
    logic signed [15:0] value;
    logic [7:0]         frames;
    logic [4:0]         kcount;
    logic               loop_en;
  } request_t;

  typedef struct {
    logic [3:0]         part;
    logic signed [15:0] ch [6];
    logic               last;
    logic               finished;
  } pose_t;

  typedef struct {
    request_t req;
    bit       typed;
    pose_t    pose;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_data = '0;

  kpi_req_if req_ch();
  kpi_rsp_if rsp_ch();

  keyframe_pose_interpolator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req(req_ch), .rsp(rsp_ch)
  );

  always #6 clk = ~clk;

  // Predictor copy of the animator state.
  logic signed [15:0] key_pose [8][16][16][6];
  int unsigned key_len [8][16];
  int unsigned motion_len [8];
  bit motion_wrap [8];
  logic signed [15:0] origin [16][3];
  int unsigned cur_motion, cur_key, frame_cnt, parts_reg;
  bit done_flag;

  pose_t poses_due[$];
  int mismatches = 0;
  int poses_seen = 0;
  int ticks_sent = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  row_t rows[$];

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint blend(longint a, longint b, int unsigned cnt, int unsigned fr);
    longint p, q;
    p = (b - a) * cnt;
    q = ((p < 0 ? -p : p) + fr / 2) / fr;
    return a + (p < 0 ? -q : q);
  endfunction

  // Updates the predicted state and queues the poses a request causes.
  task automatic animate(input request_t r);
    int unsigned cnt, nk, fr, n, key, nc;
    bit wrap;
    longint v;
    pose_t ps;
    case (r.kind)
      REQ_KEY_VALUE: if (r.chan < 6) key_pose[r.motion][r.key][r.part][r.chan] = r.value;
      REQ_KEY_FRAMES: key_len[r.motion][r.key] = (r.frames == 0) ? 1 : r.frames;
      REQ_HEADER: begin
        motion_len[r.motion] = (r.kcount == 0) ? 1 : (r.kcount > 16 ? 16 : r.kcount);
        motion_wrap[r.motion] = r.loop_en;
      end
      REQ_ORIGIN: if (r.chan < 3) origin[r.part][r.chan] = r.value;
      REQ_SELECT: if (r.motion != cur_motion) begin
        cur_motion = r.motion;
        cur_key = 0;
        frame_cnt = 0;
        done_flag = 1'b0;
      end
      REQ_TICK: begin
        cnt = motion_len[cur_motion];
        wrap = motion_wrap[cur_motion];
        if (wrap && cur_key >= cnt) cur_key = 0;
        if (wrap || cur_key < cnt) begin
          ticks_sent++;
          nk = cnt ? (cur_key + 1) % cnt : 0;
          fr = key_len[cur_motion][cur_key];
          if (fr == 0) fr = 1;
          n = (parts_reg < 1) ? 1 : (parts_reg > 16 ? 16 : parts_reg);
          nc = frame_cnt + 1;
          key = cur_key;
          if (nc >= fr) begin
            key++;
            nc = 0;
          end
          if (key >= cnt) begin
            if (wrap) key = 0;
            else done_flag = 1'b1;
          end
          for (int i = 0; i < n; i++) begin
            ps.part = 4'(i);
            for (int c = 0; c < 6; c++) begin
              v = blend(key_pose[cur_motion][cur_key][i][c],
                        key_pose[cur_motion][nk][i][c], frame_cnt, fr);
              if (c < 3) v += origin[i][c];
              ps.ch[c] = 16'(clamp16(v));
            end
            ps.last = (i + 1 == n);
            ps.finished = done_flag;
            poses_due.push_back(ps);
          end
          frame_cnt = nc;
          cur_key = key;
        end
      end
      default: ;
    endcase
  endtask

  function automatic bit same_pose(pose_t a, pose_t b);
    return a.part == b.part && a.ch == b.ch && a.last == b.last && a.finished == b.finished;
  endfunction

  function automatic void report(string tag, pose_t e, pose_t g);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: exp part %0d pos %0d %0d %0d rot %0d %0d %0d last %b fin %b",
               tag, e.part, e.ch[0], e.ch[1], e.ch[2], e.ch[3], e.ch[4], e.ch[5],
               e.last, e.finished);
      $display("  got part %0d pos %0d %0d %0d rot %0d %0d %0d last %b fin %b",
               g.part, g.ch[0], g.ch[1], g.ch[2], g.ch[3], g.ch[4], g.ch[5],
               g.last, g.finished);
    end
  endfunction

  // Result checker and watchdog.
  always @(posedge clk) begin
    pose_t got;
    if (!rst) begin
      idle_cycles++;
      if (req_ch.valid && req_ch.ready) idle_cycles = 0;
      if (rsp_ch.valid && rsp_ch.ready) begin
        idle_cycles = 0;
        poses_seen++;
        got.part = rsp_ch.part_id;
        got.ch = '{rsp_ch.pos_x, rsp_ch.pos_y, rsp_ch.pos_z,
                   rsp_ch.rot_x, rsp_ch.rot_y, rsp_ch.rot_z};
        got.last = rsp_ch.last;
        got.finished = rsp_ch.finished;
        if (poses_due.size() == 0) begin
          report("unexpected pose", got, got);
        end else begin
          if (!same_pose(poses_due[0], got)) report("pose mismatch", poses_due[0], got);
          void'(poses_due.pop_front());
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Result side back-pressure, driven at the falling edge.
  initial begin
    int stall;
    stall = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        stall--;
      end else if (!quiet && $urandom_range(0, 9) < 3) begin
        rsp_ch.ready = 1'b0;
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  task automatic send(input request_t r, input bit gaps);
    int g;
    g = 0;
    if (gaps && !quiet && $urandom_range(0, 9) < 3)
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    repeat (g) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.req_type = r.kind;
    req_ch.motion_index = r.motion;
    req_ch.key_index = r.key;
    req_ch.part_index = r.part;
    req_ch.channel = r.chan;
    req_ch.value = r.value;
    req_ch.frames = r.frames;
    req_ch.key_count = r.kcount;
    req_ch.loop_enable = r.loop_en;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    animate(r);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    req_ch.valid = 1'b0;
    while (poses_due.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic set_parts(input logic [4:0] n);
    cfg_we = 1'b1;
    cfg_data = n;
    @(negedge clk);
    cfg_we = 1'b0;
    parts_reg = n;
  endtask

  function automatic request_t make(logic [2:0] kind, int m, int k, int p, int c,
                                    int v, int f, int kc, int lp);
    request_t r;
    r.kind = kind; r.motion = 3'(m); r.key = 4'(k); r.part = 4'(p); r.chan = 3'(c);
    r.value = 16'(v); r.frames = 8'(f); r.kcount = 5'(kc); r.loop_en = 1'(lp);
    return r;
  endfunction

  function automatic request_t noise();
    request_t r;
    r.kind = 3'($urandom); r.motion = 3'($urandom); r.key = 4'($urandom);
    r.part = 4'($urandom); r.chan = 3'($urandom); r.value = 16'($urandom);
    r.frames = 8'($urandom); r.kcount = 5'($urandom);
    r.loop_en = 1'($urandom);
    return r;
  endfunction

  // Random item, weighted so that motions actually advance through their keys.
  // Ticks only ever read motion 0 keys 0 and 1 or motion 1 key 0.
  function automatic request_t pick();
    request_t r;
    int w;
    r = noise();
    w = $urandom_range(0, 99);
    if (w < 32) r.kind = REQ_TICK;
    else if (w < 56) begin
      r.kind = REQ_KEY_VALUE;
      if ($urandom_range(0, 3) == 0) r.value = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      if ($urandom_range(0, 7) != 0) r.chan = 3'($urandom_range(0, 5));
      if ($urandom_range(0, 1)) r.motion = 3'($urandom_range(0, 2));
    end else if (w < 64) begin
      r.kind = REQ_KEY_FRAMES;
      if ($urandom_range(0, 7) != 0) r.frames = 8'($urandom_range(0, 3));
    end else if (w < 71) begin
      r.kind = REQ_HEADER;
      if ($urandom_range(0, 1)) r.motion = 3'($urandom_range(0, 1));
      if (r.motion == 3'd0) r.kcount = 5'($urandom_range(0, 2));
      else if (r.motion == 3'd1) r.kcount = 5'($urandom_range(0, 1));
    end else if (w < 79) begin
      r.kind = REQ_ORIGIN;
      if ($urandom_range(0, 3) == 0) r.value = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end else if (w < 89) begin
      r.kind = REQ_SELECT;
      r.motion = 3'($urandom_range(0, 1));
    end else if (w < 93) begin
      r.kind = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
    end else begin
      r.kind = REQ_TICK;
    end
    return r;
  endfunction

  task automatic add_row(input request_t r);
    row_t x;
    x.req = r;
    x.typed = 1'b0;
    rows.push_back(x);
  endtask

  task automatic add_checked(input request_t r, input logic signed [15:0] px, input bit fin);
    row_t x;
    x.req = r;
    x.typed = 1'b1;
    x.pose.part = '0;
    x.pose.ch = '{px, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    x.pose.last = 1'b1;
    x.pose.finished = fin;
    rows.push_back(x);
  endtask

  initial begin
    logic [4:0] phase_parts [5];
    request_t tick;
    pose_t calc;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_TICK;
    req_ch.motion_index = '0;
    req_ch.key_index = '0;
    req_ch.part_index = '0;
    req_ch.channel = '0;
    req_ch.value = '0;
    req_ch.frames = '0;
    req_ch.key_count = '0;
    req_ch.loop_enable = 1'b0;
    cur_motion = 0; cur_key = 0; frame_cnt = 0; done_flag = 1'b0; parts_reg = 1;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    set_parts(5'd1);

    // Write every entry a tick can read: motion 0 keys 0 and 1, motion 1 key 0, all origins.
    quiet = 1'b1;
    send(make(REQ_HEADER, 0, 0, 0, 0, 0, 0, 2, 1), 0);
    send(make(REQ_HEADER, 1, 0, 0, 0, 0, 0, 1, 1), 0);
    for (int m = 0; m < 2; m++) begin
      for (int k = 0; k < 2 - m; k++) begin
        send(make(REQ_KEY_FRAMES, m, k, 0, 0, 0, 1, 0, 0), 0);
        for (int p = 0; p < 16; p++)
          for (int c = 0; c < 6; c++) send(make(REQ_KEY_VALUE, m, k, p, c, 0, 0, 0, 0), 0);
      end
    end
    for (int p = 0; p < 16; p++)
      for (int c = 0; c < 3; c++) send(make(REQ_ORIGIN, 0, 0, p, c, 0, 0, 0, 0), 0);
    quiet = 1'b0;

    // Directed part: extremes, saturation, wrap to key zero, finish and ignored items.
    tick = make(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(make(REQ_HEADER, 0, 0, 0, 0, 0, 0, 2, 0));
    add_row(make(REQ_KEY_FRAMES, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(make(REQ_KEY_VALUE, 0, 0, 0, 0, 32767, 0, 0, 0));
    add_row(make(REQ_KEY_VALUE, 0, 1, 0, 0, -32768, 0, 0, 0));
    add_row(make(REQ_ORIGIN, 0, 0, 0, 0, 32767, 0, 0, 0));
    add_row(make(REQ_KEY_VALUE, 0, 0, 0, 6, 1234, 0, 0, 0));
    add_row(make(REQ_ORIGIN, 0, 0, 0, 4, -5, 0, 0, 0));
    add_row(make(REQ_SPARE_A, 0, 0, 0, 0, 99, 9, 3, 1));
    add_row(make(REQ_SPARE_B, 7, 15, 15, 7, -1, 255, 31, 1));
    add_checked(tick, 16'sh7fff, 1'b0);
    add_checked(tick, -16'sd1, 1'b1);
    add_row(tick);
    add_row(make(REQ_SELECT, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(tick);
    add_row(make(REQ_SELECT, 1, 0, 0, 0, 0, 0, 0, 0));
    add_row(make(REQ_HEADER, 1, 0, 0, 0, 0, 0, 0, 1));
    add_row(make(REQ_KEY_VALUE, 1, 0, 15, 5, -32768, 0, 0, 0));
    add_row(make(REQ_KEY_FRAMES, 1, 0, 0, 0, 0, 255, 0, 0));
    add_row(tick);
    add_row(make(REQ_HEADER, 2, 0, 0, 0, 0, 0, 31, 1));
    add_row(make(REQ_SELECT, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(make(REQ_HEADER, 0, 0, 0, 0, 0, 0, 17, 1));
    add_checked(tick, 16'sh7fff, 1'b0);
    add_row(make(REQ_HEADER, 0, 0, 0, 0, 0, 0, 2, 1));
    add_row(tick);
    foreach (rows[i]) begin
      if (rows[i].typed) begin
        calc = rows[i].pose;
        send(rows[i].req, 1);
        if (poses_due.size() == 0 || !same_pose(calc, poses_due[poses_due.size() - 1]))
          report("directed pose", calc, poses_due.size() ? poses_due[poses_due.size() - 1] : calc);
      end else begin
        send(rows[i].req, 1);
      end
    end
    drain();

    // Random phases over several part counts; 0 and 31 exercise the clamp.
    phase_parts = '{5'd16, 5'd0, 5'd31, 5'd3, 5'd1};
    foreach (phase_parts[ph]) begin
      set_parts(ph == 3 ? 5'($urandom_range(2, 6)) : phase_parts[ph]);
      quiet = (ph == 2);
      repeat (18) send(pick(), 1);
      quiet = 1'b0;
      drain();
    end

    $display("Sent %0d items, %0d animating ticks, %0d poses checked,", items_sent,
             ticks_sent, poses_seen);
    $display("covering all request kinds, clamped part counts, looping and finishing motions.");
    if (mismatches == 0 && poses_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d poses missing", mismatches, poses_due.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: keyframe_pose_interpolator.f
rtl/core/kpi_pkg.sv
rtl/core/kpi_if.sv
rtl/core/kpi_ram.sv
rtl/core/kpi_div.sv
rtl/core/keyframe_pose_interpolator.sv
sim/tb_keyframe_pose_interpolator.sv
